// ----- src/esc_pkg.sv -----
// Shared constants and fixed-point helpers for the sensor compensation block.
package esc_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned NUM_REGS   = 5;

    // Register indexes.
    localparam logic [2:0] REG_TEMP_TRIM      = 3'd0;
    localparam logic [2:0] REG_PRESS_TRIM_LO  = 3'd1;
    localparam logic [2:0] REG_PRESS_TRIM_HI  = 3'd2;
    localparam logic [2:0] REG_PRESS_HUM_TRIM = 3'd3;
    localparam logic [2:0] REG_HUM_TRIM       = 3'd4;

    // Skip codes of the raw conversions.
    localparam logic [19:0] TEMP_SKIP  = 20'h80000;
    localparam logic [19:0] PRESS_SKIP = 20'h80000;
    localparam logic [15:0] HUM_SKIP   = 16'h8000;

    // Pressure status codes.
    localparam logic [1:0] PST_VALID   = 2'd0;
    localparam logic [1:0] PST_SKIPPED = 2'd1;
    localparam logic [1:0] PST_ZERODIV = 2'd2;

    localparam logic [63:0] PRESS_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BIAS47 = 64'd140737488355328;
    localparam logic [63:0] PRESS_BASE   = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE  = 64'd3125;
    localparam logic [31:0] HUM_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_MAX      = 32'd419430400;

    // Sign extension of trim fields.
    function automatic logic [63:0] sx8(input logic [7:0] x);
        return {{56{x[7]}}, x};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    // Signed division by 2**k, truncating toward zero.
    function automatic logic [63:0] sd64(input logic [63:0] x, input int unsigned k);
        logic [63:0] bias;
        bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
        return $unsigned($signed(x + bias) >>> k);
    endfunction

    function automatic logic [31:0] sd32(input logic [31:0] x, input int unsigned k);
        logic [31:0] bias;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return $unsigned($signed(x + bias) >>> k);
    endfunction

endpackage

// ----- src/environmental_sensor_compensation.sv -----
// Top level: integer temperature, pressure and humidity compensation engine.
//
//  Channel   Direction  Handshake                Contents
//  s_        in         s_tvalid / s_tready      raw temperature, pressure, humidity
//  m_        out        m_tvalid / m_tready      compensated values and status flags
//  APB       in/out     psel, penable, pready    five factory trim registers
//
// A beat with all three measurements runs 22 products through one shared 32x32
// multiplier, each followed by a post-processing step, a restoring divide at one
// bit per cycle, and six further steps. Skipped measurements shorten the
// sequence. s_tready is high only while the sequencer is idle. A finished result
// waits in the output register, and a new beat can be taken while it waits; reset
// is synchronous and active low.
module environmental_sensor_compensation (
    input  logic                            aclk,
    input  logic                            aresetn,
    // raw_temp [19:0], raw_press [39:20], raw_hum [55:40]
    input  logic [55:0]                     s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // temp_centideg [31:0], press_q24_8 [71:32], hum_q22_10 [88:72], zeros above
    output logic [95:0]                     m_tdata,
    // temp_valid [0], press_status [2:1], hum_valid [3]
    output logic [3:0]                      m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [esc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [esc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [esc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_POST, S_DIV, S_DIVE, S_PFIN, S_PCHK, S_HCHK, S_OUT
    } state_t;

    // Operations of the shared multiplier, in program order.
    typedef enum logic [4:0] {
        T_A, T_B, T_C, T_D,
        P_SQ, P_V2A, P_V2B, P_V1A, P_V1B, P_V1C, P_X, P_Q1, P_Q2, P_Q3,
        H_1, H_2, H_3, H_4, H_5, H_6, H_7, H_8
    } step_t;

    state_t      state_reg;
    step_t       step_reg;
    logic [1:0]  mul_ph_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;

    // Trim registers.
    logic [47:0] temp_trim_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [47:0] press_hum_reg;
    logic [39:0] hum_trim_reg;

    // Latched sample and working registers.
    logic [19:0] rt_reg, rp_reg;
    logic [15:0] rh_reg;
    logic [31:0] fine_reg;
    logic [31:0] tv1_reg, tv2_reg;
    logic [63:0] psq_reg, pv2_reg, pacc_reg, pv4_reg;
    logic [31:0] hx5_reg, hy2_reg, hy3_reg, hx4_reg, hx3_reg;

    // Divider.
    logic [63:0] div_rem_reg, div_quo_reg, div_den_reg;
    logic        div_neg_reg;
    logic [6:0]  div_cnt_reg;

    // Result under construction and output register.
    logic [31:0] temp_out_reg;
    logic        temp_ok_reg;
    logic [39:0] press_out_reg;
    logic [1:0]  press_st_reg;
    logic [16:0] hum_out_reg;
    logic        hum_ok_reg;
    logic [95:0] m_tdata_reg;
    logic [3:0]  m_tuser_reg;
    logic        m_tvalid_reg;

    // ---------------------------------------------------------------
    // Configuration port. Registers sit at byte address 8*i.
    // ---------------------------------------------------------------
    logic [2:0] cfg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg <= '0;
            press_lo_reg  <= '0;
            press_hi_reg  <= '0;
            press_hum_reg <= '0;
            hum_trim_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                esc_pkg::REG_TEMP_TRIM:      temp_trim_reg <= pwdata[47:0];
                esc_pkg::REG_PRESS_TRIM_LO:  press_lo_reg  <= pwdata;
                esc_pkg::REG_PRESS_TRIM_HI:  press_hi_reg  <= pwdata;
                esc_pkg::REG_PRESS_HUM_TRIM: press_hum_reg <= pwdata[47:0];
                esc_pkg::REG_HUM_TRIM:       hum_trim_reg  <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            esc_pkg::REG_TEMP_TRIM:      prdata = {16'd0, temp_trim_reg};
            esc_pkg::REG_PRESS_TRIM_LO:  prdata = press_lo_reg;
            esc_pkg::REG_PRESS_TRIM_HI:  prdata = press_hi_reg;
            esc_pkg::REG_PRESS_HUM_TRIM: prdata = {16'd0, press_hum_reg};
            esc_pkg::REG_HUM_TRIM:       prdata = {24'd0, hum_trim_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Trim fields widened to 64 bits: signed ones sign extended, t1, p1, h1, h3 zero extended, h4 kept at 16 bits.
    // ---------------------------------------------------------------
    logic [63:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h5, h6;
    logic [15:0] h4;

    assign t1 = {48'd0, temp_trim_reg[15:0]};
    assign t2 = esc_pkg::sx16(temp_trim_reg[31:16]);
    assign t3 = esc_pkg::sx16(temp_trim_reg[47:32]);
    assign p1 = {48'd0, press_lo_reg[15:0]};
    assign p2 = esc_pkg::sx16(press_lo_reg[31:16]);
    assign p3 = esc_pkg::sx16(press_lo_reg[47:32]);
    assign p4 = esc_pkg::sx16(press_lo_reg[63:48]);
    assign p5 = esc_pkg::sx16(press_hi_reg[15:0]);
    assign p6 = esc_pkg::sx16(press_hi_reg[31:16]);
    assign p7 = esc_pkg::sx16(press_hi_reg[47:32]);
    assign p8 = esc_pkg::sx16(press_hi_reg[63:48]);
    assign p9 = esc_pkg::sx16(press_hum_reg[15:0]);
    assign h1 = {56'd0, press_hum_reg[23:16]};
    assign h2 = esc_pkg::sx16(press_hum_reg[39:24]);
    assign h3 = {56'd0, press_hum_reg[47:40]};
    assign h4 = hum_trim_reg[15:0];
    assign h5 = esc_pkg::sx16(hum_trim_reg[31:16]);
    assign h6 = esc_pkg::sx8(hum_trim_reg[39:32]);

    // Values derived straight from the sample and the fine temperature.
    logic [63:0] pv1, pv4_raw, s13;
    logic [31:0] hx1, hx2, hx3c;

    assign pv1     = esc_pkg::sx32(fine_reg) - esc_pkg::PRESS_OFFSET;
    assign pv4_raw = esc_pkg::PRESS_BASE - {44'd0, rp_reg};
    assign s13     = esc_pkg::sd64(pv4_reg, 13);
    assign hx1     = fine_reg - esc_pkg::HUM_OFFSET;
    assign hx2     = {2'd0, rh_reg, 14'd0};
    assign hx3c    = {h4[11:0], 20'd0};

    // Operand selection for the shared multiplier.
    logic [63:0] op_a, op_b;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            T_A: begin
                op_a = {47'd0, rt_reg[19:3]} - {47'd0, t1[15:0], 1'b0};
                op_b = t2;
            end
            T_B: begin
                op_a = {48'd0, rt_reg[19:4]} - t1;
                op_b = op_a;
            end
            T_C:   begin op_a = esc_pkg::sx32(tv2_reg);  op_b = t3; end
            T_D:   begin op_a = esc_pkg::sx32(fine_reg); op_b = 64'd5; end
            P_SQ:  begin op_a = pv1;     op_b = pv1; end
            P_V2A: begin op_a = psq_reg; op_b = p6; end
            P_V2B: begin op_a = pv1;     op_b = p5; end
            P_V1A: begin op_a = psq_reg; op_b = p3; end
            P_V1B: begin op_a = pv1;     op_b = p2; end
            P_V1C: begin op_a = pacc_reg; op_b = p1; end
            P_X:   begin op_a = (pv4_raw << 31) - pv2_reg; op_b = esc_pkg::PRESS_SCALE; end
            P_Q1:  begin op_a = p9;      op_b = s13; end
            P_Q2:  begin op_a = psq_reg; op_b = s13; end
            P_Q3:  begin op_a = p8;      op_b = pv4_reg; end
            H_1:   begin op_a = h5; op_b = esc_pkg::sx32(hx1); end
            H_2:   begin op_a = esc_pkg::sx32(hx1); op_b = h6; end
            H_3:   begin op_a = esc_pkg::sx32(hx1); op_b = h3; end
            H_4: begin
                op_a = esc_pkg::sx32(hy2_reg);
                op_b = esc_pkg::sx32(hy3_reg + 32'd32768);
            end
            H_5:   begin op_a = esc_pkg::sx32(hx4_reg); op_b = h2; end
            H_6:   begin op_a = esc_pkg::sx32(hx5_reg); op_b = esc_pkg::sx32(hy2_reg); end
            H_7: begin
                op_a = esc_pkg::sx32(esc_pkg::sd32(hx3_reg, 15));
                op_b = op_a;
            end
            H_8:   begin op_a = esc_pkg::sx32(hx4_reg); op_b = h1; end
            default: ;
        endcase
    end

    // The 32x32 multiplier: low x low, low x high, high x low partial products
    // give the product modulo 2**64.
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;

    always_comb begin
        case (mul_ph_reg)
            2'd0:    begin mul_x = op_a[31:0];  mul_y = op_b[31:0];  end
            2'd1:    begin mul_x = op_a[31:0];  mul_y = op_b[63:32]; end
            default: begin mul_x = op_a[63:32]; mul_y = op_b[31:0];  end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // Post-processing arithmetic on the finished product.
    logic [31:0] q32;
    logic [63:0] q_abs, den_abs;
    logic [64:0] div_sh;
    logic [63:0] pfin_sum;
    logic [31:0] hum_x5;

    assign q32     = acc_reg[31:0];
    assign q_abs   = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign den_abs = pacc_reg[63] ? (64'd0 - pacc_reg) : pacc_reg;
    assign div_sh  = {div_rem_reg, div_quo_reg[63]};
    assign pfin_sum = esc_pkg::sd64(pv4_reg + pacc_reg + pv2_reg, 8) + (p7 << 4);
    assign hum_x5  = hx3_reg - esc_pkg::sd32(q32, 4);

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= T_A;
            mul_ph_reg   <= '0;
            fine_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            // The output state handles its own handshake on the result register.
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        rt_reg        <= s_tdata[19:0];
                        rp_reg        <= s_tdata[39:20];
                        rh_reg        <= s_tdata[55:40];
                        temp_out_reg  <= '0;
                        temp_ok_reg   <= 1'b0;
                        press_out_reg <= '0;
                        press_st_reg  <= esc_pkg::PST_SKIPPED;
                        hum_out_reg   <= '0;
                        hum_ok_reg    <= 1'b0;
                        mul_ph_reg    <= '0;
                        if (s_tdata[19:0] == esc_pkg::TEMP_SKIP) begin
                            state_reg <= S_PCHK;
                        end else begin
                            step_reg  <= T_A;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg   <= mul_p;
                    mul_ph_reg <= mul_ph_reg + 2'd1;
                    case (mul_ph_reg)
                        2'd0: ;
                        2'd1: acc_reg <= prod_reg;
                        2'd2: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                        default: begin
                            acc_reg   <= acc_reg + {prod_reg[31:0], 32'd0};
                            state_reg <= S_POST;
                        end
                    endcase
                end
                S_POST: begin
                    state_reg <= S_MUL;
                    case (step_reg)
                        T_A: begin tv1_reg <= esc_pkg::sd32(q32, 11); step_reg <= T_B; end
                        T_B: begin tv2_reg <= esc_pkg::sd32(q32, 12); step_reg <= T_C; end
                        T_C: begin
                            fine_reg <= tv1_reg + esc_pkg::sd32(q32, 14);
                            step_reg <= T_D;
                        end
                        T_D: begin
                            temp_out_reg <= esc_pkg::sd32(q32 + 32'd128, 8);
                            temp_ok_reg  <= 1'b1;
                            state_reg    <= S_PCHK;
                        end
                        P_SQ:  begin psq_reg <= acc_reg; step_reg <= P_V2A; end
                        P_V2A: begin pv2_reg <= acc_reg + (p4 << 35); step_reg <= P_V2B; end
                        P_V2B: begin pv2_reg <= pv2_reg + (acc_reg << 17); step_reg <= P_V1A; end
                        P_V1A: begin pacc_reg <= esc_pkg::sd64(acc_reg, 8); step_reg <= P_V1B; end
                        P_V1B: begin
                            pacc_reg <= pacc_reg + (acc_reg << 12) + esc_pkg::PRESS_BIAS47;
                            step_reg <= P_V1C;
                        end
                        P_V1C: begin
                            pacc_reg <= esc_pkg::sd64(acc_reg, 33);
                            if (esc_pkg::sd64(acc_reg, 33) == 64'd0) begin
                                // A zero divisor ends the pressure path early.
                                press_out_reg <= '0;
                                press_st_reg  <= esc_pkg::PST_ZERODIV;
                                state_reg     <= S_HCHK;
                            end else begin
                                step_reg <= P_X;
                            end
                        end
                        P_X: begin
                            div_quo_reg <= q_abs;
                            div_rem_reg <= '0;
                            div_den_reg <= den_abs;
                            div_neg_reg <= acc_reg[63] ^ pacc_reg[63];
                            div_cnt_reg <= '0;
                            state_reg   <= S_DIV;
                        end
                        P_Q1:  begin psq_reg <= acc_reg; step_reg <= P_Q2; end
                        P_Q2:  begin pacc_reg <= esc_pkg::sd64(acc_reg, 25); step_reg <= P_Q3; end
                        P_Q3: begin
                            pv2_reg   <= esc_pkg::sd64(acc_reg, 19);
                            state_reg <= S_PFIN;
                        end
                        H_1: begin
                            hx5_reg  <= esc_pkg::sd32(hx2 - hx3c - q32 + 32'd16384, 15);
                            step_reg <= H_2;
                        end
                        H_2: begin hy2_reg <= esc_pkg::sd32(q32, 10); step_reg <= H_3; end
                        H_3: begin hy3_reg <= esc_pkg::sd32(q32, 11); step_reg <= H_4; end
                        H_4: begin
                            hx4_reg  <= esc_pkg::sd32(q32, 10) + 32'd2097152;
                            step_reg <= H_5;
                        end
                        H_5: begin hy2_reg <= esc_pkg::sd32(q32 + 32'd8192, 14); step_reg <= H_6; end
                        H_6: begin hx3_reg <= q32; step_reg <= H_7; end
                        H_7: begin hx4_reg <= esc_pkg::sd32(q32, 7); step_reg <= H_8; end
                        H_8: begin
                            // Clamp to 0..100 percent, then drop to Q22.10.
                            if (hum_x5[31]) begin
                                hum_out_reg <= '0;
                            end else if (hum_x5 > esc_pkg::HUM_MAX) begin
                                hum_out_reg <= esc_pkg::HUM_MAX[28:12];
                            end else begin
                                hum_out_reg <= hum_x5[28:12];
                            end
                            hum_ok_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    div_cnt_reg <= div_cnt_reg + 7'd1;
                    if (div_sh >= {1'b0, div_den_reg}) begin
                        div_rem_reg <= 64'(div_sh - {1'b0, div_den_reg});
                        div_quo_reg <= {div_quo_reg[62:0], 1'b1};
                    end else begin
                        div_rem_reg <= div_sh[63:0];
                        div_quo_reg <= {div_quo_reg[62:0], 1'b0};
                    end
                    if (div_cnt_reg == 7'd63) begin
                        state_reg <= S_DIVE;
                    end
                end
                S_DIVE: begin
                    pv4_reg    <= div_neg_reg ? (64'd0 - div_quo_reg) : div_quo_reg;
                    step_reg   <= P_Q1;
                    mul_ph_reg <= '0;
                    state_reg  <= S_MUL;
                end
                S_PFIN: begin
                    // Saturate to the signed 40-bit range.
                    if (!pfin_sum[63] && (pfin_sum[62:39] != '0)) begin
                        press_out_reg <= {1'b0, {39{1'b1}}};
                    end else if (pfin_sum[63] && (pfin_sum[62:39] != '1)) begin
                        press_out_reg <= {1'b1, 39'd0};
                    end else begin
                        press_out_reg <= pfin_sum[39:0];
                    end
                    press_st_reg <= esc_pkg::PST_VALID;
                    state_reg    <= S_HCHK;
                end
                S_PCHK: begin
                    if (rp_reg == esc_pkg::PRESS_SKIP) begin
                        state_reg <= S_HCHK;
                    end else begin
                        step_reg  <= P_SQ;
                        state_reg <= S_MUL;
                    end
                end
                S_HCHK: begin
                    if (rh_reg == esc_pkg::HUM_SKIP) begin
                        state_reg <= S_OUT;
                    end else begin
                        step_reg  <= H_1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'd0, hum_out_reg, press_out_reg, temp_out_reg};
                        m_tuser_reg  <= {hum_ok_reg, press_st_reg, temp_ok_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef ASSERT_OFF
    a_fine_kept_on_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[19:0] == esc_pkg::TEMP_SKIP)) |=> $stable(fine_reg))
        else $error("fine temperature changed on a skipped temperature sample");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while a sample is in work");

    a_div_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> !div_cnt_reg[6])
        else $error("divider ran past 64 steps");
`endif

endmodule

// ----- bench/environmental_sensor_compensation_tb.sv -----
// Testbench for the sensor compensation block: random and directed raw samples, scoreboard.
`timescale 1ns / 1ps

module environmental_sensor_compensation_tb;

    // One compensated result as it leaves the master side.
    typedef struct {
        logic [31:0] temp;
        logic        temp_ok;
        logic [39:0] press;
        logic [1:0]  press_st;
        logic [16:0] hum;
        logic        hum_ok;
    } comp_result_t;

    // Predicts each compensated sample from the raw beat and checks the results in order.
    class comp_scoreboard;
        logic [63:0]  trim [esc_pkg::NUM_REGS];
        longint       fine_t;
        comp_result_t pending_q[$];
        int           errors;

        function new();
            for (int i = 0; i < esc_pkg::NUM_REGS; i++) trim[i] = '0;
            fine_t = 0;
            errors = 0;
        endfunction

        static function longint wrap32(longint x);
            return longint'($signed(x[31:0]));
        endfunction

        // Signed 64-bit division on bit patterns, truncating toward zero.
        static function logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
            logic [63:0] ua;
            logic [63:0] ub;
            logic [63:0] q;
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = ua / ub;
            return (a[63] != b[63]) ? -q : q;
        endfunction

        function void note_sample(logic [55:0] raw);
            logic [19:0] rt;
            logic [19:0] rp;
            logic [15:0] rh;
            comp_result_t e;
            longint t1, t2, t3, adc, a, b, v1s, v2s;
            logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, v4;
            longint r;
            longint h1, h2, h3, h4, h5, h6, x1, x2, x3, x4, x5;

            rt = raw[19:0];
            rp = raw[39:20];
            rh = raw[55:40];
            e = '{32'd0, 1'b0, 40'd0, esc_pkg::PST_SKIPPED, 17'd0, 1'b0};

            // Temperature first; a skipped sample keeps the old fine temperature.
            if (rt != esc_pkg::TEMP_SKIP) begin
                t1 = longint'(trim[0][15:0]);
                t2 = longint'($signed(trim[0][31:16]));
                t3 = longint'($signed(trim[0][47:32]));
                adc = longint'(rt);
                a = adc / 8 - t1 * 2;
                v1s = wrap32(a * t2) / 2048;
                b = adc / 16 - t1;
                v2s = wrap32(b * b) / 4096;
                v2s = wrap32(v2s * t3) / 16384;
                fine_t = wrap32(v1s + v2s);
                e.temp = 32'(wrap32(wrap32(fine_t * 5) + 128) / 256);
                e.temp_ok = 1'b1;
            end

            // Pressure works on 64-bit patterns that wrap.
            if (rp != esc_pkg::PRESS_SKIP) begin
                p1 = 64'(trim[1][15:0]);
                p2 = 64'($signed(trim[1][31:16]));
                p3 = 64'($signed(trim[1][47:32]));
                p4 = 64'($signed(trim[1][63:48]));
                p5 = 64'($signed(trim[2][15:0]));
                p6 = 64'($signed(trim[2][31:16]));
                p7 = 64'($signed(trim[2][47:32]));
                p8 = 64'($signed(trim[2][63:48]));
                p9 = 64'($signed(trim[3][15:0]));
                v1 = 64'(fine_t) - 64'd128000;
                v2 = v1 * v1 * p6;
                v2 = v2 + v1 * p5 * 64'd131072;
                v2 = v2 + p4 * 64'd34359738368;
                v1 = div_trunc(v1 * v1 * p3, 64'd256) + v1 * p2 * 64'd4096;
                v1 = div_trunc((64'd140737488355328 + v1) * p1, 64'd8589934592);
                if (v1 == 64'd0) begin
                    e.press_st = esc_pkg::PST_ZERODIV;
                end else begin
                    v4 = 64'd1048576 - 64'(rp);
                    v4 = div_trunc((v4 * 64'd2147483648 - v2) * 64'd3125, v1);
                    v1 = div_trunc(p9 * div_trunc(v4, 64'd8192) * div_trunc(v4, 64'd8192),
                                   64'd33554432);
                    v2 = div_trunc(p8 * v4, 64'd524288);
                    v4 = div_trunc(v4 + v1 + v2, 64'd256) + p7 * 64'd16;
                    r = longint'($signed(v4));
                    if (r > 64'sd549755813887) r = 64'sd549755813887;
                    if (r < -64'sd549755813888) r = -64'sd549755813888;
                    e.press = r[39:0];
                    e.press_st = esc_pkg::PST_VALID;
                end
            end

            // Humidity, 32-bit wrapping intermediates, clamped at the end.
            if (rh != esc_pkg::HUM_SKIP) begin
                h1 = longint'(trim[3][23:16]);
                h2 = longint'($signed(trim[3][39:24]));
                h3 = longint'(trim[3][47:40]);
                h4 = longint'($signed(trim[4][15:0]));
                h5 = longint'($signed(trim[4][31:16]));
                h6 = longint'($signed(trim[4][39:32]));
                x1 = wrap32(fine_t - 76800);
                x2 = wrap32(longint'(rh) * 16384);
                x3 = wrap32(h4 * 1048576);
                x4 = wrap32(h5 * x1);
                x5 = wrap32(wrap32(wrap32(x2 - x3) - x4) + 16384) / 32768;
                x2 = wrap32(x1 * h6) / 1024;
                x3 = wrap32(x1 * h3) / 2048;
                x4 = wrap32(wrap32(x2 * wrap32(x3 + 32768)) / 1024 + 2097152);
                x2 = wrap32(wrap32(x4 * h2) + 8192) / 16384;
                x3 = wrap32(x5 * x2);
                x4 = wrap32((x3 / 32768) * (x3 / 32768)) / 128;
                x5 = wrap32(x3 - wrap32(x4 * h1) / 16);
                if (x5 < 0) x5 = 0;
                if (x5 > 419430400) x5 = 419430400;
                e.hum = 17'(x5 / 4096);
                e.hum_ok = 1'b1;
            end
            pending_q.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [95:0] data, logic [3:0] flags);
            comp_result_t e;
            if (pending_q.size() == 0) begin
                report("result beat with nothing expected", data[63:0], 64'd0);
            end else begin
                e = pending_q.pop_front();
                if (data[31:0] !== e.temp) report("temp_centideg", data[31:0], e.temp);
                if (flags[0] !== e.temp_ok) report("temp_valid", flags[0], e.temp_ok);
                if (data[71:32] !== e.press) report("press_q24_8", data[71:32], e.press);
                if (flags[2:1] !== e.press_st) report("press_status", flags[2:1], e.press_st);
                if (data[88:72] !== e.hum) report("hum_q22_10", data[88:72], e.hum);
                if (flags[3] !== e.hum_ok) report("hum_valid", flags[3], e.hum_ok);
            end
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic [55:0]                    s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [95:0]                    m_tdata;
    logic [3:0]                     m_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [esc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [esc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [esc_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // Percentages of cycles in which the sender and the receiver hold off.
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    comp_scoreboard sb = new();

    // Typical factory trim words; several phases start from these.
    localparam logic [63:0] NOM_TEMP_TRIM  = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] NOM_PRESS_LO   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] NOM_PRESS_HI   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] NOM_PRESS_HUM  = {16'd0, 8'd0, 16'd370, 8'd75, 16'd6000};
    localparam logic [63:0] NOM_HUM_TRIM   = {24'd0, 8'd30, 16'd50, 16'd313};

    environmental_sensor_compensation u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The receiver stalls at random; it is held low through reset.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both channels are observed at the clock edge, before any driver update lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    // The predictor's copy is updated at once, which is safe since writes happen only when idle.
    task write_trim(logic [2:0] idx, logic [63:0] value);
        logic [63:0] mask;
        mask = (idx == esc_pkg::REG_TEMP_TRIM || idx == esc_pkg::REG_PRESS_HUM_TRIM) ?
               64'hFFFF_FFFF_FFFF :
               (idx == esc_pkg::REG_HUM_TRIM) ? 64'hFF_FFFF_FFFF : '1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= esc_pkg::CFG_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.trim[idx] = value & mask;
    endtask

    task write_all_trims(logic [63:0] t0, logic [63:0] t1, logic [63:0] t2,
                         logic [63:0] t3, logic [63:0] t4);
        write_trim(esc_pkg::REG_TEMP_TRIM, t0);
        write_trim(esc_pkg::REG_PRESS_TRIM_LO, t1);
        write_trim(esc_pkg::REG_PRESS_TRIM_HI, t2);
        write_trim(esc_pkg::REG_PRESS_HUM_TRIM, t3);
        write_trim(esc_pkg::REG_HUM_TRIM, t4);
    endtask

    // Stops offering beats, waits until every result is in, then lets the block settle.
    task drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    // Offers one beat and holds it until accepted. s_tvalid stays high into the
    // next call unless a gap is drawn, so it is never lowered and raised in one step.
    task send_sample(logic [55:0] raw);
        s_tdata  <= raw;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // One raw field: sometimes the skip code, often near a realistic reading,
    // otherwise anything the field can hold.
    function automatic logic [19:0] pick_raw(logic [19:0] skip, logic [19:0] nominal,
                                             logic [19:0] fmask);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) return skip;
        if (sel < 55) return (nominal + 20'($urandom_range(40000)) - 20'd20000) & fmask;
        return 20'($urandom) & fmask;
    endfunction

    function automatic logic [55:0] random_sample();
        logic [19:0] rt;
        logic [19:0] rp;
        logic [19:0] rh;
        rt = pick_raw(esc_pkg::TEMP_SKIP, 20'd519888, 20'hFFFFF);
        rp = pick_raw(esc_pkg::PRESS_SKIP, 20'd415148, 20'hFFFFF);
        rh = pick_raw(20'(esc_pkg::HUM_SKIP), 20'd30000, 20'h0FFFF);
        return {rh[15:0], rp, rt};
    endfunction

    task send_random(int unsigned count);
        for (int i = 0; i < count; i++) send_sample(random_sample());
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        send_gap_pct   = 11;
        recv_stall_pct = 47;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed samples under typical trims: skip codes, field extremes and a
        // realistic reading, with temperature skipped between them so the stale
        // fine temperature is exercised.
        write_all_trims(NOM_TEMP_TRIM, NOM_PRESS_LO, NOM_PRESS_HI, NOM_PRESS_HUM, NOM_HUM_TRIM);
        send_sample({16'd30000, 20'd415148, 20'd519888});
        send_sample({16'd30000, 20'd415148, esc_pkg::TEMP_SKIP});
        send_sample({16'd30000, esc_pkg::PRESS_SKIP, 20'd519888});
        send_sample({esc_pkg::HUM_SKIP, 20'd415148, 20'd519888});
        send_sample({esc_pkg::HUM_SKIP, esc_pkg::PRESS_SKIP, esc_pkg::TEMP_SKIP});
        send_sample({16'd0, 20'd0, 20'd0});
        send_sample({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        send_sample({16'd0, 20'hFFFFF, esc_pkg::TEMP_SKIP});
        send_sample({16'hFFFF, 20'd0, 20'd0});
        send_sample({16'h7FFF, 20'h7FFFF, 20'h7FFFF});
        send_sample({16'h8001, 20'h80001, 20'h80001});
        send_sample({16'd65000, 20'd100000, 20'd300000});
        send_sample({16'd1000, 20'd700000, 20'd700000});
        drain_results();

        // A zero first pressure trim gives the zero divisor status.
        write_trim(esc_pkg::REG_PRESS_TRIM_LO, NOM_PRESS_LO & ~64'hFFFF);
        send_sample({16'd30000, 20'd415148, 20'd519888});
        send_sample({16'd30000, 20'd0, esc_pkg::TEMP_SKIP});
        drain_results();
        write_trim(esc_pkg::REG_PRESS_TRIM_LO, NOM_PRESS_LO);

        send_random(200);
        // Hold the sender until the pipeline is completely empty, then resume.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        send_random(200);
        drain_results();

        // Fully random trims with the idling roles swapped.
        send_gap_pct   = 47;
        recv_stall_pct = 11;
        write_all_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
        send_random(200);
        drain_results();
        write_all_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
        send_random(200);
        drain_results();

        // No idling: extreme trims, then typical ones with small random offsets.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_all_trims('1, '1, '1, '1, '1);
        send_random(130);
        drain_results();
        write_all_trims('0, '0, '0, '0, '0);
        send_random(100);
        drain_results();
        write_all_trims({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
                        {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                        {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                        {16'h0, 8'hFF, 16'h8000, 8'hFF, 16'h7FFF},
                        {24'h0, 8'h80, 16'h7FFF, 16'h8000});
        send_random(100);
        drain_results();
        write_all_trims(NOM_TEMP_TRIM ^ (64'($urandom) & 64'h000F_000F_000F),
                        NOM_PRESS_LO ^ {$urandom, $urandom} & 64'h000F_000F_000F_000F,
                        NOM_PRESS_HI ^ {$urandom, $urandom} & 64'h000F_000F_000F_000F,
                        NOM_PRESS_HUM ^ (64'($urandom) & 64'h0F_000F_0F_000F),
                        NOM_HUM_TRIM ^ (64'($urandom) & 64'h07_000F_000F));
        send_random(100);
        drain_results();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
